// ----- hdl/dsa_pkg.sv -----
// dsa_pkg: shared types, sizes and helpers for the descriptor slot allocator
// no dependencies; used by every module under hdl/ except dsa_ram, and by the bench
package dsa_pkg;

  localparam int MAX_SLOTS     = 1024;
  localparam int INITIAL_SLOTS = 20;
  localparam int EXTENT_SLOTS  = 50;

  localparam int WORD_W = 32;                        // bitmap bits per ram row
  localparam int ROWS   = MAX_SLOTS / WORD_W;
  localparam int ROW_W  = $clog2(ROWS);
  localparam int BIT_W  = $clog2(WORD_W);
  localparam int SLOT_W = $clog2(MAX_SLOTS);
  localparam int CNT_W  = SLOT_W + 1;                // holds MAX_SLOTS itself
  localparam int CFG_W  = 11;
  localparam int EXP_W  = 8;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_OPEN  = 2'd1,
    CMD_FREE  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_PLIMIT = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  localparam logic REG_PLIMIT = 1'b0;
  localparam logic REG_SLIMIT = 1'b1;

  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] idx;
  } ffs_res_t;

  typedef struct packed {
    logic [BIT_W-1:0] lo;        // first bit at or above the scan pointer
    logic             hi_en;     // search end falls inside this row
    logic [BIT_W-1:0] hi;        // first bit past the search end
  } ffs_win_t;

  // register values above the table size mean unlimited
  function automatic logic [CFG_W-1:0] clamp_limit(input logic [CFG_W-1:0] v);
    logic [CFG_W-1:0] m;
    m = CFG_W'(MAX_SLOTS);
    return (v > m) ? m : v;
  endfunction

  function automatic logic [CFG_W-1:0] min_cnt(input logic [CFG_W-1:0] a,
                                               input logic [CFG_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

endpackage

// ----- hdl/dsa_ram.sv -----
// dsa_ram: generic single-write, single-read ram with registered read data
// no dependencies
module dsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/dsa_bitmap.sv -----
// dsa_bitmap: used-slot bitmap, one ram row per 32 slots plus per-row valid flags
// depends on dsa_pkg and dsa_ram; rows never written read back as all free
module dsa_bitmap (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [dsa_pkg::ROW_W-1:0]   rd_row,
  output logic [dsa_pkg::WORD_W-1:0]  rd_word,
  input  logic                        wr_en,
  input  logic [dsa_pkg::ROW_W-1:0]   wr_row,
  input  logic [dsa_pkg::WORD_W-1:0]  wr_word
);
  import dsa_pkg::*;

  logic [ROWS-1:0]   vld_r;
  logic              rd_vld_r;
  logic [WORD_W-1:0] ram_q;

  dsa_ram #(.WIDTH(WORD_W), .DEPTH(ROWS)) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_row),
    .wdata (wr_word),
    .raddr (rd_row),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_row] <= 1'b1;
      end
      rd_vld_r <= vld_r[rd_row];
    end
  end

  assign rd_word = rd_vld_r ? ram_q : '0;

endmodule

// ----- hdl/dsa_ffs.sv -----
// dsa_ffs: lowest free slot inside one bitmap row, limited to a bit window
// depends on dsa_pkg
module dsa_ffs (
  input  logic [dsa_pkg::WORD_W-1:0] word,
  input  dsa_pkg::ffs_win_t          win,
  output dsa_pkg::ffs_res_t          res
);
  import dsa_pkg::*;

  logic [WORD_W-1:0] cand;

  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      cand[b] = !word[b] && (BIT_W'(b) >= win.lo) && (!win.hi_en || BIT_W'(b) < win.hi);
    end
  end

  // priority encode from the top so the lowest candidate wins
  always_comb begin
    res.found = |cand;
    res.idx   = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (cand[b]) begin
        res.idx = BIT_W'(b);
      end
    end
  end

endmodule

// ----- hdl/descriptor_slot_allocator.sv -----
// descriptor_slot_allocator: an accepted word runs its scan cycles in S_SCAN, then S_DONE
// moves the result to the output registers, where out_valid rises; S_DONE waits while an older
// result is still held by out_stall. a scan cycle reads one 32-slot row or grows the capacity;
// a miss ends in a closing scan cycle. free and no-op words go straight to S_DONE. the next
// word is taken once each result is registered, also while it still waits on out_stall.
// synchronous reset: bitmap reads empty via per-row valid flags, no clearing pass; hint, mark,
// counts cleared, capacity to initial size, both limits to 1024.
module descriptor_slot_allocator (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 in_command,
  input  logic [dsa_pkg::SLOT_W-1:0] in_want,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 out_status,
  output logic [dsa_pkg::SLOT_W-1:0] out_descriptor,
  output logic [dsa_pkg::SLOT_W-1:0] out_highest_used,
  output logic [dsa_pkg::CNT_W-1:0]  out_open_files,
  output logic [dsa_pkg::EXP_W-1:0]  out_expansions,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic                       cfg_index,
  input  logic [dsa_pkg::CFG_W-1:0]  cfg_data
);
  import dsa_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  state_t            state_r, state_nxt;
  logic              is_open_r, is_open_nxt;
  logic [SLOT_W-1:0] want_r, want_nxt;
  logic [CNT_W-1:0]  ptr_r, ptr_nxt;
  logic [CNT_W-1:0]  lim_r, lim_nxt;
  logic [CNT_W-1:0]  cap_r, cap_nxt;
  logic [SLOT_W-1:0] hint_r, hint_nxt;
  logic [SLOT_W-1:0] high_r, high_nxt;
  logic [CNT_W-1:0]  open_r, open_nxt;
  logic [EXP_W-1:0]  exp_r, exp_nxt;
  logic [CFG_W-1:0]  plim_r, plim_nxt;
  logic [CFG_W-1:0]  slim_r, slim_nxt;
  status_t           res_status_r, res_status_nxt;
  logic [SLOT_W-1:0] res_desc_r, res_desc_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        out_status_r, out_status_nxt;
  logic [SLOT_W-1:0] out_desc_r, out_desc_nxt;
  logic [SLOT_W-1:0] out_high_r, out_high_nxt;
  logic [CNT_W-1:0]  out_open_r, out_open_nxt;
  logic [EXP_W-1:0]  out_exp_r, out_exp_nxt;

  logic [ROW_W-1:0]  rd_row;
  logic [WORD_W-1:0] rd_word;
  logic              wr_en;
  logic [WORD_W-1:0] wr_word;
  logic [WORD_W-1:0] wr_mask;
  ffs_win_t          win;
  ffs_res_t          ffs;
  logic [CNT_W-1:0]  last;
  logic [CNT_W-1:0]  start;
  logic [CNT_W-1:0]  scan_from;
  logic [CNT_W:0]    cap_dbl;
  logic [CNT_W-1:0]  cap_grown;
  logic [SLOT_W-1:0] slot;

  dsa_bitmap u_bitmap (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_row  (rd_row),
    .rd_word (rd_word),
    .wr_en   (wr_en),
    .wr_row  (ptr_r[BIT_W +: ROW_W]),
    .wr_word (wr_word)
  );

  dsa_ffs u_ffs (
    .word (rd_word),
    .win  (win),
    .res  (ffs)
  );

  assign last      = min_cnt(cap_r, lim_r);
  assign scan_from = (want_r < hint_r) ? CNT_W'(hint_r) : CNT_W'(want_r);
  assign win.lo    = ptr_r[BIT_W-1:0];
  assign win.hi_en = (last[CNT_W-1:BIT_W] == ptr_r[CNT_W-1:BIT_W]);
  assign win.hi    = last[BIT_W-1:0];
  assign slot      = {ptr_r[BIT_W +: ROW_W], ffs.idx};
  assign wr_mask   = WORD_W'(1) << ffs.idx;
  assign wr_word   = rd_word | wr_mask;

  // next capacity: jump to the extent size, then double, never past the table
  assign cap_dbl   = {cap_r, 1'b0};
  assign cap_grown = (cap_r < CNT_W'(EXTENT_SLOTS)) ? CNT_W'(EXTENT_SLOTS) :
                     (cap_dbl > (CNT_W + 1)'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) :
                     cap_dbl[CNT_W-1:0];

  always_comb begin
    state_nxt      = state_r;
    is_open_nxt    = is_open_r;
    want_nxt       = want_r;
    ptr_nxt        = ptr_r;
    lim_nxt        = lim_r;
    cap_nxt        = cap_r;
    hint_nxt       = hint_r;
    high_nxt       = high_r;
    open_nxt       = open_r;
    exp_nxt        = exp_r;
    plim_nxt       = plim_r;
    slim_nxt       = slim_r;
    res_status_nxt = res_status_r;
    res_desc_nxt   = res_desc_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_desc_nxt   = out_desc_r;
    out_high_nxt   = out_high_r;
    out_open_nxt   = out_open_r;
    out_exp_nxt    = out_exp_r;
    wr_en          = 1'b0;
    start          = '0;
    rd_row         = ptr_r[BIT_W +: ROW_W];

    if (cfg_valid) begin
      if (cfg_index == REG_PLIMIT) begin
        plim_nxt = cfg_data;
      end else begin
        slim_nxt = cfg_data;
      end
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_command)
            CMD_ALLOC, CMD_OPEN: begin
              is_open_nxt = (in_command == CMD_OPEN);
              want_nxt    = (in_command == CMD_OPEN) ? '0 : in_want;
              start       = (want_nxt < hint_r) ? CNT_W'(hint_r) : CNT_W'(want_nxt);
              ptr_nxt     = start;
              rd_row      = start[BIT_W +: ROW_W];
              lim_nxt     = min_cnt(clamp_limit(plim_r), clamp_limit(slim_r));
              state_nxt   = S_SCAN;
            end
            CMD_FREE: begin
              if (open_r != '0) begin
                open_nxt = open_r - CNT_W'(1);
              end
              res_status_nxt = ST_OK;
              res_desc_nxt   = '0;
              state_nxt      = S_DONE;
            end
            default: begin
              res_status_nxt = ST_OK;
              res_desc_nxt   = '0;
              state_nxt      = S_DONE;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (ptr_r >= last) begin
          if (cap_r >= lim_r) begin
            res_status_nxt = ST_PLIMIT;
            res_desc_nxt   = '0;
            state_nxt      = S_DONE;
          end else begin
            // grow, then go on from the old end, or from the search start if that is higher
            cap_nxt = cap_grown;
            if (exp_r != '1) begin
              exp_nxt = exp_r + EXP_W'(1);
            end
            ptr_nxt = (last > scan_from) ? last : scan_from;
            rd_row  = ptr_nxt[BIT_W +: ROW_W];
          end
        end else if (ffs.found) begin
          if (slot > high_r) begin
            high_nxt = slot;
          end
          if (want_r <= hint_r) begin
            hint_nxt = slot;
          end
          if (is_open_r && (open_r >= clamp_limit(slim_r))) begin
            res_status_nxt = ST_FULL;
            res_desc_nxt   = '0;
          end else begin
            wr_en          = 1'b1;
            res_status_nxt = ST_OK;
            res_desc_nxt   = slot;
            if (is_open_r) begin
              open_nxt = open_r + CNT_W'(1);
            end
          end
          state_nxt = S_DONE;
        end else begin
          ptr_nxt = {ptr_r[CNT_W-1:BIT_W] + (CNT_W - BIT_W)'(1), {BIT_W{1'b0}}};
          rd_row  = ptr_nxt[BIT_W +: ROW_W];
        end
      end

      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_desc_nxt   = res_desc_r;
          out_high_nxt   = high_r;
          out_open_nxt   = open_r;
          out_exp_nxt    = exp_r;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cap_r       <= CNT_W'(INITIAL_SLOTS);
      hint_r      <= '0;
      high_r      <= '0;
      open_r      <= '0;
      exp_r       <= '0;
      plim_r      <= CFG_W'(1024);
      slim_r      <= CFG_W'(1024);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cap_r       <= cap_nxt;
      hint_r      <= hint_nxt;
      high_r      <= high_nxt;
      open_r      <= open_nxt;
      exp_r       <= exp_nxt;
      plim_r      <= plim_nxt;
      slim_r      <= slim_nxt;
    end
    is_open_r    <= is_open_nxt;
    want_r       <= want_nxt;
    ptr_r        <= ptr_nxt;
    lim_r        <= lim_nxt;
    res_status_r <= res_status_nxt;
    res_desc_r   <= res_desc_nxt;
    out_status_r <= out_status_nxt;
    out_desc_r   <= out_desc_nxt;
    out_high_r   <= out_high_nxt;
    out_open_r   <= out_open_nxt;
    out_exp_r    <= out_exp_nxt;
  end

  assign in_stall         = (state_r != S_IDLE);
  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_descriptor   = out_desc_r;
  assign out_highest_used = out_high_r;
  assign out_open_files   = out_open_r;
  assign out_expansions   = out_exp_r;

  // an accepted word always leaves idle in the cycle after it is taken
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r != S_IDLE))
    else $error("accepted word did not start work");

  // a slot is only ever marked when the bitmap shows it free
  a_mark_free: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> ((rd_word & wr_mask) == '0))
    else $error("marked a slot that was already used");

  // the scan pointer never drops below where the search started
  a_ptr_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (ptr_r >= scan_from))
    else $error("scan pointer below search start");

  // capacity stays within the table
  a_cap_max: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |=> (cap_r <= CNT_W'(MAX_SLOTS)))
    else $error("capacity beyond table size");

endmodule

// ----- bench/dsa_reply_checker.sv -----
`timescale 1ns / 1ps
// dsa_reply_checker: predicts every reply word of the descriptor slot allocator from
// the accepted command words and limit writes, and compares field by field; uses dsa_pkg
module dsa_reply_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic [1:0]                 in_command,
  input  logic [dsa_pkg::SLOT_W-1:0] in_want,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic [1:0]                 out_status,
  input  logic [dsa_pkg::SLOT_W-1:0] out_descriptor,
  input  logic [dsa_pkg::SLOT_W-1:0] out_highest_used,
  input  logic [dsa_pkg::CNT_W-1:0]  out_open_files,
  input  logic [dsa_pkg::EXP_W-1:0]  out_expansions,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic                       cfg_index,
  input  logic [dsa_pkg::CFG_W-1:0]  cfg_data,
  output int                         fail_count,
  output int                         replies_owed
);
  import dsa_pkg::*;

  typedef struct {
    status_t           status;
    logic [SLOT_W-1:0] descriptor;
    logic [SLOT_W-1:0] highest;
    logic [CNT_W-1:0]  open_files;
    logic [EXP_W-1:0]  expansions;
  } reply_t;

  reply_t owed_q[$];

  bit                slot_taken [MAX_SLOTS];
  logic [SLOT_W-1:0] hint;
  logic [SLOT_W-1:0] mark;
  logic [CNT_W-1:0]  table_cap;
  logic [CNT_W-1:0]  open_cnt;
  logic [EXP_W-1:0]  grow_cnt;
  logic [CFG_W-1:0]  proc_lim;
  logic [CFG_W-1:0]  sys_lim;

  initial begin
    fail_count   = 0;
    replies_owed = 0;
  end

  // anything past the table size means no limit
  function automatic int unsigned limit_value(input logic [CFG_W-1:0] v);
    return (v > MAX_SLOTS) ? MAX_SLOTS : v;
  endfunction

  // lowest free slot at or above max(lowest, hint), growing the table as needed
  function automatic bit find_free(input int unsigned lowest, output int unsigned slot);
    int unsigned lim;
    int unsigned last;
    int unsigned i;
    int          pass;
    lim = limit_value(proc_lim);
    if (limit_value(sys_lim) < lim) lim = limit_value(sys_lim);
    slot = 0;
    for (pass = 0; pass < 8; pass++) begin
      last = (table_cap < lim) ? table_cap : lim;
      i = (lowest < hint) ? hint : lowest;
      while (i < last) begin
        if (!slot_taken[i]) begin
          if (i > mark) mark = SLOT_W'(i);
          if (lowest <= hint) hint = SLOT_W'(i);
          slot = i;
          return 1'b1;
        end
        i++;
      end
      if (table_cap >= lim) return 1'b0;
      if (table_cap < EXTENT_SLOTS) table_cap = CNT_W'(EXTENT_SLOTS);
      else if (2 * table_cap > MAX_SLOTS) table_cap = CNT_W'(MAX_SLOTS);
      else table_cap = table_cap << 1;
      if (grow_cnt != {EXP_W{1'b1}}) grow_cnt++;
    end
    return 1'b0;
  endfunction

  function automatic reply_t predict_reply(input cmd_t cmd, input logic [SLOT_W-1:0] want);
    reply_t      r;
    int unsigned slot;
    r.status     = ST_OK;
    r.descriptor = '0;
    case (cmd)
      CMD_ALLOC: begin
        if (!find_free(want, slot)) r.status = ST_PLIMIT;
        else begin
          slot_taken[slot] = 1'b1;
          r.descriptor = SLOT_W'(slot);
        end
      end
      CMD_OPEN: begin
        // search runs first, so hint and mark move even when the table is full
        if (!find_free(0, slot)) r.status = ST_PLIMIT;
        else if (open_cnt >= limit_value(sys_lim)) r.status = ST_FULL;
        else begin
          open_cnt++;
          slot_taken[slot] = 1'b1;
          r.descriptor = SLOT_W'(slot);
        end
      end
      CMD_FREE: begin
        if (open_cnt != 0) open_cnt--;
      end
      default: ;
    endcase
    r.highest    = mark;
    r.open_files = open_cnt;
    r.expansions = grow_cnt;
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int exp_val);
    if (fail_count < 100)
      $display("%0t: reply %s mismatch, got %0d expected %0d", $time, what, got, exp_val);
    fail_count++;
  endtask

  always @(posedge clk) begin
    reply_t owed;
    if (!rst_n) begin
      foreach (slot_taken[i]) slot_taken[i] = 1'b0;
      hint      = '0;
      mark      = '0;
      table_cap = CNT_W'(INITIAL_SLOTS);
      open_cnt  = '0;
      grow_cnt  = '0;
      proc_lim  = CFG_W'(1024);
      sys_lim   = CFG_W'(1024);
      owed_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_PLIMIT) proc_lim = cfg_data;
        else sys_lim = cfg_data;
      end
      // retire before predicting so a stray word never meets its own expectation
      if (out_valid && !out_stall) begin
        if (owed_q.size() == 0) flag_mismatch("word with nothing owed", 1, 0);
        else begin
          owed = owed_q.pop_front();
          if (out_status !== owed.status) flag_mismatch("status", out_status, owed.status);
          if (out_descriptor !== owed.descriptor)
            flag_mismatch("descriptor", out_descriptor, owed.descriptor);
          if (out_highest_used !== owed.highest)
            flag_mismatch("highest_used", out_highest_used, owed.highest);
          if (out_open_files !== owed.open_files)
            flag_mismatch("open_files", out_open_files, owed.open_files);
          if (out_expansions !== owed.expansions)
            flag_mismatch("expansions", out_expansions, owed.expansions);
        end
      end
      if (in_valid && !in_stall) owed_q.push_back(predict_reply(cmd_t'(in_command), in_want));
    end
    replies_owed <= owed_q.size();
  end

endmodule

// ----- bench/descriptor_slot_allocator_tb.sv -----
`timescale 1ns / 1ps
// descriptor_slot_allocator_tb: drives command words and limit writes into the allocator,
// with random gaps and output stalls; dsa_reply_checker does the prediction and compare
module descriptor_slot_allocator_tb;
  import dsa_pkg::*;

  localparam int RUN_LIMIT = 400000;

  logic              clk;
  logic              rst_n      = 1'b0;
  logic              in_valid   = 1'b0;
  logic              in_stall;
  logic [1:0]        in_command = CMD_NOP;
  logic [SLOT_W-1:0] in_want    = '0;
  logic              out_valid;
  logic              out_stall  = 1'b0;
  logic [1:0]        out_status;
  logic [SLOT_W-1:0] out_descriptor;
  logic [SLOT_W-1:0] out_highest_used;
  logic [CNT_W-1:0]  out_open_files;
  logic [EXP_W-1:0]  out_expansions;
  logic              cfg_valid  = 1'b0;
  logic              cfg_ready;
  logic              cfg_index  = REG_PLIMIT;
  logic [CFG_W-1:0]  cfg_data   = '0;

  int               fail_count;
  int               replies_owed;
  int               cycle_count = 0;
  int               stall_left  = 0;
  bit               calm        = 1'b0;
  logic [CFG_W-1:0] cur_plim    = CFG_W'(1024);
  logic [CFG_W-1:0] cur_slim    = CFG_W'(1024);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  descriptor_slot_allocator dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_want          (in_want),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_descriptor   (out_descriptor),
    .out_highest_used (out_highest_used),
    .out_open_files   (out_open_files),
    .out_expansions   (out_expansions),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  dsa_reply_checker replies (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_command       (in_command),
    .in_want          (in_want),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_descriptor   (out_descriptor),
    .out_highest_used (out_highest_used),
    .out_open_files   (out_open_files),
    .out_expansions   (out_expansions),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .fail_count       (fail_count),
    .replies_owed     (replies_owed)
  );

  // output stall bursts of random length
  always @(posedge clk) begin
    if (!rst_n || calm) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 9);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_word(input cmd_t cmd, input logic [SLOT_W-1:0] w);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_command <= cmd;
    in_want    <= w;
    do @(posedge clk); while (in_stall);
  endtask

  // limits are only rewritten once every owed reply word is back
  task automatic reconfigure(input logic [CFG_W-1:0] plim, input logic [CFG_W-1:0] slim);
    in_valid <= 1'b0;
    @(posedge clk);
    while (replies_owed != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= REG_PLIMIT;
    cfg_data  <= plim;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= REG_SLIMIT;
    cfg_data  <= slim;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_plim = plim;
    cur_slim = slim;
  endtask

  task automatic run_random(input int count);
    int unsigned eff;
    int unsigned pick;
    int unsigned w;
    cmd_t        cmd;
    eff = (cur_plim > MAX_SLOTS) ? MAX_SLOTS : cur_plim;
    if (cur_slim < eff) eff = cur_slim;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) cmd = CMD_ALLOC;
      else if (pick < 80) cmd = CMD_OPEN;
      else if (pick < 92) cmd = CMD_FREE;
      else cmd = CMD_NOP;
      // mostly wants inside the live range, some anywhere
      pick = $urandom_range(0, 99);
      if (pick < 15 || eff == 0) w = $urandom_range(0, MAX_SLOTS - 1);
      else if (pick < 30) w = 0;
      else w = $urandom_range(0, eff - 1);
      send_word(cmd, SLOT_W'(w));
    end
  endtask

  initial begin
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    reconfigure(CFG_W'(1024), CFG_W'(1024));
    send_word(CMD_FREE, SLOT_W'(517));      // free with no files open
    send_word(CMD_NOP, SLOT_W'(1023));
    send_word(CMD_ALLOC, SLOT_W'(0));
    send_word(CMD_OPEN, SLOT_W'(0));
    send_word(CMD_OPEN, SLOT_W'(341));
    send_word(CMD_FREE, SLOT_W'(0));
    send_word(CMD_ALLOC, SLOT_W'(19));      // want above hint leaves the hint alone
    send_word(CMD_ALLOC, SLOT_W'(19));      // first growth to the extent size
    send_word(CMD_ALLOC, SLOT_W'(60));      // doubling
    send_word(CMD_ALLOC, SLOT_W'(1023));    // grows all the way to the table size
    send_word(CMD_ALLOC, SLOT_W'(1023));    // nothing left at the top
    send_word(CMD_OPEN, SLOT_W'(1023));

    reconfigure(CFG_W'(0), CFG_W'(1024));   // zero process limit
    send_word(CMD_ALLOC, SLOT_W'(0));
    send_word(CMD_OPEN, SLOT_W'(0));
    reconfigure(CFG_W'(1024), CFG_W'(0));   // zero system limit
    send_word(CMD_OPEN, SLOT_W'(0));
    send_word(CMD_ALLOC, SLOT_W'(5));
    reconfigure(CFG_W'(2047), CFG_W'(1025)); // both beyond the table mean unlimited
    send_word(CMD_ALLOC, SLOT_W'(1000));
    send_word(CMD_OPEN, SLOT_W'(0));
    send_word(CMD_FREE, SLOT_W'(682));
    send_word(CMD_NOP, SLOT_W'(0));

    reconfigure(CFG_W'(64), CFG_W'(2047));
    run_random(100);
    reconfigure(CFG_W'(2047), CFG_W'(150));
    run_random(100);
    reconfigure(CFG_W'(0), CFG_W'(1024));
    run_random(20);
    reconfigure(CFG_W'(300), CFG_W'(1024));
    calm <= 1'b1;
    run_random(120);
    reconfigure(CFG_W'(1024), CFG_W'(0));
    calm <= 1'b0;
    run_random(20);
    reconfigure(CFG_W'($urandom_range(300, 700)), CFG_W'(1025));
    run_random(150);
    reconfigure(CFG_W'(2047), CFG_W'(2047));
    run_random(200);
    reconfigure(CFG_W'(1024), CFG_W'(1024));
    calm <= 1'b1;
    run_random(240);

    in_valid <= 1'b0;
    @(posedge clk);
    while (replies_owed != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- files.f -----
hdl/dsa_pkg.sv
hdl/dsa_ram.sv
hdl/dsa_bitmap.sv
hdl/dsa_ffs.sv
hdl/descriptor_slot_allocator.sv
bench/dsa_reply_checker.sv
bench/descriptor_slot_allocator_tb.sv
